>>> rtl/lsoa_pkg.sv
// Shared types and constants for the lidar sector obstacle avoider.
package lsoa_pkg;

    typedef logic signed [16:0] sector_t;

    // Sector slots
    localparam logic [1:0] SEC_FRONT = 2'd0;
    localparam logic [1:0] SEC_BACK  = 2'd1;
    localparam logic [1:0] SEC_LEFT  = 2'd2;
    localparam logic [1:0] SEC_RIGHT = 2'd3;
    localparam int         SEC_COUNT = 4;

    // Avoidance mode
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_SIDE   = 2'd1;
    localparam logic [1:0] MODE_BACKUP = 2'd2;

    // Slide side
    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_BAD   = 2'd2;
    localparam logic [1:0] SIDE_RIGHT = 2'd3;

    // Move codes
    localparam logic [2:0] MV_STOP  = 3'd0;
    localparam logic [2:0] MV_GO    = 3'd1;
    localparam logic [2:0] MV_BACK  = 3'd2;
    localparam logic [2:0] MV_LEFT  = 3'd3;
    localparam logic [2:0] MV_RIGHT = 3'd4;

    // Command bytes
    localparam logic [7:0] CMD_GO    = 8'h67;
    localparam logic [7:0] CMD_BACK  = 8'h62;
    localparam logic [7:0] CMD_LEFT  = 8'h6c;
    localparam logic [7:0] CMD_RIGHT = 8'h72;
    localparam logic [7:0] CMD_STOP  = 8'h73;

    // Beat kinds
    localparam logic ACT_POINT = 1'b0;
    localparam logic ACT_SCAN  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_STOP     = 2'd0;
    localparam logic [1:0] CFG_CLEAR    = 2'd1;
    localparam logic [1:0] CFG_BACK_MIN = 2'd2;

    localparam logic [15:0] STOP_RESET     = 16'd300;
    localparam logic [15:0] CLEAR_RESET    = 16'd500;
    localparam logic [15:0] BACK_MIN_RESET = 16'd300;

    // Angle thresholds: degrees * 16384, compared against angle * 90
    localparam logic [22:0] ANG_FRONT_LO = 23'(124 * 16384);
    localparam logic [22:0] ANG_FRONT_HI = 23'(236 * 16384);
    localparam logic [22:0] ANG_BACK_LO  = 23'(30 * 16384);
    localparam logic [22:0] ANG_BACK_HI  = 23'(330 * 16384);

    localparam sector_t SECTOR_UNMEASURED = -17'sd1;

endpackage

>>> rtl/lidar_sector_obstacle_avoider_core.sv
// Lidar sector binning and obstacle avoidance state machine, single-pass core.
// A result appears on the outputs in the cycle after its end-of-scan beat is accepted.
// Throughput: one input beat per cycle; each point does one angle compare and one min update.
// The output register parts the channels: input stalls only while a result waits and is stalled.
// Reset (rst_n low, asynchronous): all sectors -1, avoid mode and slide side cleared,
// thresholds back to 300 / 500 / 300 mm, no result pending.
module lidar_sector_obstacle_avoider_core (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [15:0]        point_angle,
    input  logic [17:0]        point_range,
    input  logic [7:0]         command,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         move_code,
    output logic signed [16:0] front_range,
    output logic signed [16:0] back_range,
    output logic signed [16:0] left_range,
    output logic signed [16:0] right_range,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    // Threshold registers
    logic [15:0] stop_reg, clear_reg, back_min_reg;

    // Scan state
    lsoa_pkg::sector_t sector_reg [lsoa_pkg::SEC_COUNT];
    lsoa_pkg::sector_t sector_next [lsoa_pkg::SEC_COUNT];
    logic [1:0] mode_reg, mode_next;
    logic [1:0] side_reg, side_next;

    // Result register
    logic       out_valid_reg, out_valid_next;
    logic [2:0] move_reg;
    lsoa_pkg::sector_t front_reg, back_reg, left_reg, right_reg;

    logic in_acc;
    logic out_acc;

    assign out_acc   = out_valid_reg && !out_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid   = out_valid_reg;
    assign move_code   = move_reg;
    assign front_range = front_reg;
    assign back_range  = back_reg;
    assign left_range  = left_reg;
    assign right_range = right_reg;

    // ------------------------------------------------------------------
    // Point binning: angle * 90 by shift-add (64 + 16 + 8 + 2), 23 bits.
    // ------------------------------------------------------------------
    logic [22:0] ang_scaled;
    logic [15:0] dist_mm;
    lsoa_pkg::sector_t dist_s;
    logic        in_front, in_back, in_left, in_right;
    logic [1:0]  hit_idx;
    logic        hit;
    lsoa_pkg::sector_t cur, upd;

    assign ang_scaled = {1'b0, point_angle, 6'b0} + {3'b0, point_angle, 4'b0}
                      + {4'b0, point_angle, 3'b0} + {6'b0, point_angle, 1'b0};
    assign dist_mm    = point_range[17:2];
    assign dist_s     = $signed({1'b0, dist_mm});

    assign in_front = (ang_scaled >= lsoa_pkg::ANG_FRONT_LO)
                   && (ang_scaled <= lsoa_pkg::ANG_FRONT_HI);
    assign in_back  = !in_front && ((ang_scaled <= lsoa_pkg::ANG_BACK_LO)
                   || (ang_scaled >= lsoa_pkg::ANG_BACK_HI));
    assign in_left  = !in_front && !in_back && (ang_scaled < lsoa_pkg::ANG_FRONT_LO);
    assign in_right = !in_front && !in_back && (ang_scaled > lsoa_pkg::ANG_FRONT_HI)
                   && (ang_scaled < lsoa_pkg::ANG_BACK_HI);

    always_comb
    begin
        hit_idx = lsoa_pkg::SEC_FRONT;
        hit     = 1'b0;
        if (in_front)
        begin
            hit_idx = lsoa_pkg::SEC_FRONT;
            hit     = 1'b1;
        end
        else if (in_back)
        begin
            // too-near back points are dropped outright
            hit_idx = lsoa_pkg::SEC_BACK;
            hit     = (dist_mm > back_min_reg);
        end
        else if (in_left)
        begin
            hit_idx = lsoa_pkg::SEC_LEFT;
            hit     = 1'b1;
        end
        else if (in_right)
        begin
            hit_idx = lsoa_pkg::SEC_RIGHT;
            hit     = 1'b1;
        end
    end

    // nearest nonzero wins; an empty (<=0) sector or zero distance takes the max
    assign cur = sector_reg[hit_idx];
    always_comb
    begin
        if (cur <= 17'sd0 || dist_mm == 16'd0)
            upd = (dist_s > cur) ? dist_s : cur;
        else
            upd = (dist_s < cur) ? dist_s : cur;
    end

    // ------------------------------------------------------------------
    // Avoidance decision on end-of-scan beats.
    // ------------------------------------------------------------------
    lsoa_pkg::sector_t f_s, b_s, l_s, r_s, clr_s, stp_s;
    logic       f_blocked;
    logic [2:0] mv;
    logic [1:0] dec_mode, dec_side;
    logic       back_free;

    assign f_s   = sector_reg[lsoa_pkg::SEC_FRONT];
    assign b_s   = sector_reg[lsoa_pkg::SEC_BACK];
    assign l_s   = sector_reg[lsoa_pkg::SEC_LEFT];
    assign r_s   = sector_reg[lsoa_pkg::SEC_RIGHT];
    assign clr_s = $signed({1'b0, clear_reg});
    assign stp_s = $signed({1'b0, stop_reg});

    assign f_blocked = (f_s > 17'sd0) && (f_s <= stp_s);
    assign back_free = (b_s == 17'sd0) || (b_s > clr_s);

    always_comb
    begin
        mv       = lsoa_pkg::MV_STOP;
        dec_mode = mode_reg;
        dec_side = side_reg;
        if (command == lsoa_pkg::CMD_STOP
            && (mode_reg != lsoa_pkg::MODE_NONE || side_reg != lsoa_pkg::SIDE_NONE))
        begin
            dec_mode = lsoa_pkg::MODE_NONE;
            dec_side = lsoa_pkg::SIDE_NONE;
        end
        else if (command == lsoa_pkg::CMD_GO && !f_s[16]
                 && mode_reg != lsoa_pkg::MODE_SIDE)
        begin
            dec_side = lsoa_pkg::SIDE_NONE;
            if (f_blocked)
            begin
                if (mode_reg != lsoa_pkg::MODE_BACKUP
                    && (((l_s > clr_s) && (l_s >= r_s) && (r_s > 17'sd0))
                        || l_s == 17'sd0))
                begin
                    dec_mode = lsoa_pkg::MODE_SIDE;
                    dec_side = lsoa_pkg::SIDE_LEFT;
                    mv       = lsoa_pkg::MV_LEFT;
                end
                else if (mode_reg != lsoa_pkg::MODE_BACKUP
                         && (((r_s > clr_s) && (l_s <= r_s) && (l_s > 17'sd0))
                             || r_s == 17'sd0))
                begin
                    dec_mode = lsoa_pkg::MODE_SIDE;
                    dec_side = lsoa_pkg::SIDE_RIGHT;
                    mv       = lsoa_pkg::MV_RIGHT;
                end
                else if (back_free)
                begin
                    dec_mode = lsoa_pkg::MODE_BACKUP;
                    mv       = lsoa_pkg::MV_BACK;
                end
                else
                begin
                    dec_mode = lsoa_pkg::MODE_NONE;
                end
            end
            else
            begin
                dec_mode = lsoa_pkg::MODE_NONE;
                mv       = lsoa_pkg::MV_GO;
            end
        end
        else if ((command == lsoa_pkg::CMD_LEFT || side_reg == lsoa_pkg::SIDE_LEFT)
                 && !l_s[16])
        begin
            if (mode_reg == lsoa_pkg::MODE_NONE && side_reg == lsoa_pkg::SIDE_NONE)
                mv = lsoa_pkg::MV_LEFT;
            else if (mode_reg == lsoa_pkg::MODE_SIDE && side_reg == lsoa_pkg::SIDE_LEFT)
            begin
                if (f_blocked)
                    mv = (l_s < clr_s) ? lsoa_pkg::MV_STOP : lsoa_pkg::MV_LEFT;
                else
                begin
                    dec_mode = lsoa_pkg::MODE_NONE;
                    mv       = lsoa_pkg::MV_LEFT;
                end
            end
            else if (mode_reg == lsoa_pkg::MODE_NONE && side_reg == lsoa_pkg::SIDE_LEFT)
            begin
                if (r_s > 17'sd0 && r_s <= clr_s)
                    mv = f_blocked ? lsoa_pkg::MV_STOP : lsoa_pkg::MV_GO;
                else
                    dec_side = lsoa_pkg::SIDE_NONE;
            end
        end
        else if ((command == lsoa_pkg::CMD_RIGHT || side_reg == lsoa_pkg::SIDE_RIGHT)
                 && !r_s[16])
        begin
            if (mode_reg == lsoa_pkg::MODE_NONE && side_reg == lsoa_pkg::SIDE_NONE)
                mv = lsoa_pkg::MV_RIGHT;
            else if (mode_reg == lsoa_pkg::MODE_SIDE && side_reg == lsoa_pkg::SIDE_RIGHT)
            begin
                if (f_blocked)
                    mv = (r_s < clr_s) ? lsoa_pkg::MV_STOP : lsoa_pkg::MV_RIGHT;
                else
                    dec_mode = lsoa_pkg::MODE_NONE;
            end
            else if (mode_reg == lsoa_pkg::MODE_NONE && side_reg == lsoa_pkg::SIDE_RIGHT)
            begin
                // pass check looks at the left sector
                if (l_s > 17'sd0 && l_s <= clr_s)
                    mv = f_blocked ? lsoa_pkg::MV_STOP : lsoa_pkg::MV_GO;
                else
                    dec_side = lsoa_pkg::SIDE_NONE;
            end
        end
        else if (command == lsoa_pkg::CMD_BACK && !b_s[16])
        begin
            mv = (b_s > 17'sd0 && b_s <= clr_s) ? lsoa_pkg::MV_STOP : lsoa_pkg::MV_BACK;
        end
        else
        begin
            dec_mode = lsoa_pkg::MODE_NONE;
            dec_side = lsoa_pkg::SIDE_NONE;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < lsoa_pkg::SEC_COUNT; i++)
            sector_next[i] = sector_reg[i];
        mode_next = mode_reg;
        side_next = side_reg;
        if (in_acc)
        begin
            if (action == lsoa_pkg::ACT_SCAN)
            begin
                for (int i = 0; i < lsoa_pkg::SEC_COUNT; i++)
                    sector_next[i] = lsoa_pkg::SECTOR_UNMEASURED;
                mode_next = dec_mode;
                side_next = dec_side;
            end
            else if (hit)
            begin
                sector_next[hit_idx] = upd;
            end
        end
    end

    always_comb
    begin
        if (in_acc && action == lsoa_pkg::ACT_SCAN)
            out_valid_next = 1'b1;
        else if (out_acc)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lsoa_pkg::SEC_COUNT; i++)
                sector_reg[i] <= lsoa_pkg::SECTOR_UNMEASURED;
            mode_reg      <= lsoa_pkg::MODE_NONE;
            side_reg      <= lsoa_pkg::SIDE_NONE;
            out_valid_reg <= 1'b0;
            stop_reg      <= lsoa_pkg::STOP_RESET;
            clear_reg     <= lsoa_pkg::CLEAR_RESET;
            back_min_reg  <= lsoa_pkg::BACK_MIN_RESET;
        end
        else
        begin
            for (int i = 0; i < lsoa_pkg::SEC_COUNT; i++)
                sector_reg[i] <= sector_next[i];
            mode_reg      <= mode_next;
            side_reg      <= side_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lsoa_pkg::CFG_STOP:     stop_reg     <= cfg_data;
                    lsoa_pkg::CFG_CLEAR:    clear_reg    <= cfg_data;
                    lsoa_pkg::CFG_BACK_MIN: back_min_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // result payload: snapshot of the sectors before they go back to -1
    always_ff @(posedge clk)
    begin
        if (in_acc && action == lsoa_pkg::ACT_SCAN)
        begin
            move_reg  <= mv;
            front_reg <= f_s;
            back_reg  <= b_s;
            left_reg  <= l_s;
            right_reg <= r_s;
        end
    end

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    a_scan_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && action == lsoa_pkg::ACT_SCAN) |=> out_valid)
        else $error("end-of-scan beat gave no result");

    a_point_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && action == lsoa_pkg::ACT_POINT && !out_valid) |=> !out_valid)
        else $error("point beat produced a result");

    a_sectors_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && action == lsoa_pkg::ACT_SCAN)
        |=> (sector_reg[lsoa_pkg::SEC_FRONT] == lsoa_pkg::SECTOR_UNMEASURED
             && sector_reg[lsoa_pkg::SEC_RIGHT] == lsoa_pkg::SECTOR_UNMEASURED))
        else $error("sectors not reset after end of scan");

    a_side_legal: assert property (@(posedge clk) disable iff (!rst_n)
        side_reg != lsoa_pkg::SIDE_BAD)
        else $error("slide side took an unused code");

    a_move_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (move_code <= lsoa_pkg::MV_RIGHT))
        else $error("move code out of range");
`endif

endmodule
